@@ hdl/olis_pkg.sv @@
// shared types, codes and constants for the ordered list core
package olis_pkg;

	localparam int CAPACITY_DEFAULT = 64;
	localparam int POS_W = 7;
	localparam int VAL_W = 8;

	localparam logic [VAL_W-1:0] FIRST_CHAR = 8'h61;
	localparam logic [VAL_W-1:0] LAST_CHAR  = 8'h65;
	localparam int INIT_LEN = int'(LAST_CHAR - FIRST_CHAR) + 1;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_READ,
		OP_FIND
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_NOTFOUND,
		ST_FULL
	} status_t;

	typedef struct packed {
		opcode_t          opcode;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] data;
		logic [POS_W-1:0] found_position;
		logic [POS_W-1:0] list_length;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             take;
		logic             ins;
		logic             del;
		logic             rd;
		logic             fnd;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

	// power-up contents: the first cells hold the letters, the rest zero
	function automatic logic [VAL_W-1:0] init_entry(int idx);
		if (idx < INIT_LEN) begin
			return FIRST_CHAR + VAL_W'(idx);
		end
		return '0;
	endfunction

endpackage

@@ hdl/olis_chan_if.sv @@
// valid/ready channel carrying one item of payload type T
interface olis_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/olis_cell.sv @@
// one list cell: holds an entry, shifts with its neighbors, flags a hit
module olis_cell #(
	parameter int                            IDX  = 0,
	parameter int                            XW   = 7,
	parameter logic [olis_pkg::VAL_W-1:0]    INIT = '0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olis_pkg::cell_ctl_t           ctl,
	input  logic [XW-1:0]                 pos,
	input  logic [XW-1:0]                 cnt,
	input  logic [olis_pkg::VAL_W-1:0]    left,
	input  logic [olis_pkg::VAL_W-1:0]    right,
	output logic [olis_pkg::VAL_W-1:0]    entry,
	output logic                          hit
);

	localparam logic [XW-1:0] IDX_X  = XW'(IDX);
	localparam logic [XW-1:0] IDX1_X = XW'(IDX + 1);

	logic [olis_pkg::VAL_W-1:0] entry_q;
	logic [olis_pkg::VAL_W-1:0] entry_d;
	logic                       hit_q;
	logic                       hit_d;
	logic                       live;

	always_comb begin
		live    = IDX_X < cnt;
		entry_d = entry_q;
		if (ctl.ins) begin
			if (IDX_X == pos) begin
				entry_d = ctl.value;
			end else if (IDX_X > pos && IDX_X <= cnt) begin
				entry_d = left;
			end
		end else if (ctl.del) begin
			if (IDX1_X >= pos && IDX1_X < cnt) begin
				entry_d = right;
			end
		end
		hit_d = (ctl.fnd && live && entry_q == ctl.value) || (ctl.rd && IDX1_X == pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= INIT;
		end else begin
			entry_q <= entry_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			hit_q <= hit_d;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

@@ hdl/olis_pick.sv @@
// first-hit picker: isolates the lowest flagged cell, returns its index and entry
module olis_pick #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  logic [N-1:0]                          sel,
	input  logic [N-1:0][olis_pkg::VAL_W-1:0]     entries,
	output logic                                  any,
	output logic [IW-1:0]                         idx,
	output logic [olis_pkg::VAL_W-1:0]            data
);

	logic [N-1:0] onehot;

	// lowest set bit
	assign onehot = sel & (~sel + N'(1));
	assign any    = |sel;

	always_comb begin
		idx  = '0;
		data = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				idx  = idx | IW'(i);
				data = data | entries[i];
			end
		end
	end

endmodule

@@ hdl/ordered_list_insert_delete_search_core.sv @@
// ordered list core: chain of entry cells with insert, delete, read and find
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  req     | in  | opcode, position, value                          | valid/ready
//  rsp     | out | status, data, found_position, list_length        | valid/ready
//
// an accepted item updates the cells and latches its hit flags at its own clock
// edge; the first-hit pick runs in the next cycle and its result is loaded into rsp
// once the output register is free or being drained
// sustained rate is one item per cycle; req.ready drops only while an item sits
// in the pick stage and the result ahead of it waits in rsp
// reset loads the first five cells with a..e and sets the length to five,
// with both pipeline slots empty
module ordered_list_insert_delete_search_core #(
	parameter int CAPACITY = olis_pkg::CAPACITY_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	olis_chan_if.sink   req,
	olis_chan_if.source rsp
);

	// count has to reach CAPACITY itself
	localparam int CW = $clog2(CAPACITY + 1);
	// compare width covers both the position field and the count
	localparam int XW = (CW > olis_pkg::POS_W) ? CW : olis_pkg::POS_W;
	localparam int IW = $clog2(CAPACITY);

	logic [CW-1:0]             count_q;
	logic [XW-1:0]             pos_x;
	logic [XW-1:0]             cnt_x;
	logic                      take;
	logic                      advance;
	olis_pkg::status_t         status_d;
	olis_pkg::cell_ctl_t       ctl;

	// pick stage
	logic                      s1_valid_q;
	olis_pkg::opcode_t         op_s1;
	olis_pkg::status_t         status_s1;

	// output register
	logic                      rsp_valid_q;
	olis_pkg::rsp_t            rsp_q;
	olis_pkg::rsp_t            rsp_d;

	// the chain
	logic [CAPACITY-1:0][olis_pkg::VAL_W-1:0] entry_w;
	logic [CAPACITY-1:0][olis_pkg::VAL_W-1:0] left_w;
	logic [CAPACITY-1:0][olis_pkg::VAL_W-1:0] right_w;
	logic [CAPACITY-1:0]                      hit_w;

	logic                      pick_any;
	logic [IW-1:0]             pick_idx;
	logic [olis_pkg::VAL_W-1:0] pick_data;

	assign pos_x = XW'(req.payload.position);
	assign cnt_x = XW'(count_q);

	// pick stage empties when the output register is free or being drained
	assign advance   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || advance;
	assign take      = req.valid && req.ready;

	// position and capacity checks; find settles its status in the pick stage
	always_comb begin
		status_d = olis_pkg::ST_OK;
		unique case (req.payload.opcode)
			olis_pkg::OP_INSERT: begin
				if (pos_x > cnt_x) begin
					status_d = olis_pkg::ST_RANGE;
				end else if (count_q == CW'(CAPACITY)) begin
					status_d = olis_pkg::ST_FULL;
				end
			end
			olis_pkg::OP_DELETE, olis_pkg::OP_READ: begin
				if (pos_x == '0 || pos_x > cnt_x) begin
					status_d = olis_pkg::ST_RANGE;
				end
			end
			olis_pkg::OP_FIND: begin
				status_d = olis_pkg::ST_OK;
			end
			default: begin
				status_d = olis_pkg::ST_OK;
			end
		endcase
	end

	// broadcast to the cells; shifts only on a legal request
	always_comb begin
		ctl.take  = take;
		ctl.ins   = take && req.payload.opcode == olis_pkg::OP_INSERT
			&& status_d == olis_pkg::ST_OK;
		ctl.del   = take && req.payload.opcode == olis_pkg::OP_DELETE
			&& status_d == olis_pkg::ST_OK;
		ctl.rd    = take && req.payload.opcode == olis_pkg::OP_READ
			&& status_d == olis_pkg::ST_OK;
		ctl.fnd   = take && req.payload.opcode == olis_pkg::OP_FIND;
		ctl.value = req.payload.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(olis_pkg::INIT_LEN);
		end else if (ctl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.del) begin
			count_q <= count_q - 1'b1;
		end
	end

	// cell row: each cell sees its lower and upper neighbor, ends tied off
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_lo_end
			assign left_w[g] = '0;
		end else begin : g_lo
			assign left_w[g] = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_hi_end
			assign right_w[g] = '0;
		end else begin : g_hi
			assign right_w[g] = entry_w[g+1];
		end

		olis_cell #(
			.IDX  (g),
			.XW   (XW),
			.INIT (olis_pkg::init_entry(g))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.pos    (pos_x),
			.cnt    (cnt_x),
			.left   (left_w[g]),
			.right  (right_w[g]),
			.entry  (entry_w[g]),
			.hit    (hit_w[g])
		);
	end

	// hit flags are one-hot for a read, any pattern for a find
	olis_pick #(
		.N  (CAPACITY),
		.IW (IW)
	) u_pick (
		.sel     (hit_w),
		.entries (entry_w),
		.any     (pick_any),
		.idx     (pick_idx),
		.data    (pick_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1     <= req.payload.opcode;
			status_s1 <= status_d;
		end
	end

	// result assembly; count already reflects this item's update
	always_comb begin
		rsp_d.status         = status_s1;
		rsp_d.data           = '0;
		rsp_d.found_position = '0;
		rsp_d.list_length    = olis_pkg::POS_W'(count_q);
		if (op_s1 == olis_pkg::OP_FIND) begin
			if (pick_any) begin
				rsp_d.status         = olis_pkg::ST_OK;
				rsp_d.found_position = olis_pkg::POS_W'(pick_idx) + olis_pkg::POS_W'(1);
			end else begin
				rsp_d.status = olis_pkg::ST_NOTFOUND;
			end
		end else if (op_s1 == olis_pkg::OP_READ && status_s1 == olis_pkg::ST_OK) begin
			rsp_d.data = pick_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

@@ hdl/olis_check.sv @@
// port-level checks for the ordered list core, bound to the top level
module olis_check #(
	parameter int CAPACITY = olis_pkg::CAPACITY_DEFAULT
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input olis_pkg::rsp_t rsp_payload
);

	// a stalled result holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
		else $error("result changed while stalled");

	// with an item in the pick stage and the output blocked, no new item
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 (rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("item taken while both stages are full");

	// a full status only shows at full length
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_payload.status == olis_pkg::ST_FULL)
		|-> (rsp_payload.list_length == olis_pkg::POS_W'(CAPACITY)))
		else $error("full status with short list");

	// no answer fields on an error
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_payload.status != olis_pkg::ST_OK)
		|-> (rsp_payload.data == '0 && rsp_payload.found_position == '0))
		else $error("answer fields set on error");

endmodule

bind ordered_list_insert_delete_search_core olis_check #(
	.CAPACITY (CAPACITY)
) u_olis_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

@@ dv/testbench.sv @@
// self-checking testbench for the ordered list core: directed script, then random traffic
module testbench;
	import olis_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int LIST_CAP     = CAPACITY_DEFAULT;
	localparam int RANDOM_ITEMS = 1950;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	olis_chan_if #(.T(req_t)) req_if ();
	olis_chan_if #(.T(rsp_t)) rsp_if ();

	ordered_list_insert_delete_search_core #(
		.CAPACITY(LIST_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow copy of the list contents and length, advanced at each accepted item
	logic [VAL_W-1:0] shadow_list [LIST_CAP];
	int unsigned      shadow_len;

	// results still owed by the core, oldest first
	rsp_t        list_replies_due [$];
	script_row_t opening_script [$];

	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned status_seen [4];
	int unsigned peak_len;
	int unsigned empty_hits;
	int unsigned burst_left;

	// receiver stall pattern state
	int unsigned stall_mode = 0;
	int unsigned stall_mode_left = 0;
	int unsigned stall_run = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// predicted outcome of one request, updating the shadow list as the core should
	function automatic rsp_t apply_list_op(input req_t r);
		rsp_t res;
		int unsigned pos;
		int unsigned i;
		res = '0;
		res.status = ST_OK;
		pos = 32'(r.position);
		case (r.opcode)
			OP_INSERT: begin
				// range check wins over the full check
				if (pos > shadow_len) begin
					res.status = ST_RANGE;
				end else if (shadow_len >= LIST_CAP) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--) begin
						shadow_list[i] = shadow_list[i-1];
					end
					shadow_list[pos] = r.value;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (pos == 0 || pos > shadow_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = pos - 1; i + 1 < shadow_len; i++) begin
						shadow_list[i] = shadow_list[i+1];
					end
					shadow_len--;
				end
			end
			OP_READ: begin
				if (pos == 0 || pos > shadow_len) begin
					res.status = ST_RANGE;
				end else begin
					res.data = shadow_list[pos-1];
				end
			end
			default: begin
				// first match wins; position field plays no part
				res.status = ST_NOTFOUND;
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_list[i] == r.value) begin
						res.status = ST_OK;
						res.found_position = POS_W'(i + 1);
						break;
					end
				end
			end
		endcase
		res.list_length = POS_W'(shadow_len);
		return res;
	endfunction

	// random request, mostly legal for the current length, with some noise
	function automatic req_t pick_request(input bit growing);
		req_t r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r.value = VAL_W'($urandom);
		if (growing) begin
			if (roll < 55) r.opcode = OP_INSERT;
			else if (roll < 70) r.opcode = OP_DELETE;
			else if (roll < 85) r.opcode = OP_READ;
			else r.opcode = OP_FIND;
		end else begin
			if (roll < 15) r.opcode = OP_INSERT;
			else if (roll < 65) r.opcode = OP_DELETE;
			else if (roll < 80) r.opcode = OP_READ;
			else r.opcode = OP_FIND;
		end
		// any 7-bit pattern now and then, else a position inside the legal span (a low one when empty)
		if ($urandom_range(0, 9) == 0) begin
			r.position = POS_W'($urandom);
		end else if (r.opcode == OP_INSERT) begin
			r.position = POS_W'($urandom_range(0, shadow_len));
		end else if (shadow_len == 0) begin
			r.position = POS_W'($urandom_range(0, 2));
		end else begin
			r.position = POS_W'($urandom_range(1, shadow_len));
		end
		// finds mostly look for something that is there
		if (r.opcode == OP_FIND && shadow_len != 0 && $urandom_range(0, 2) != 0) begin
			r.value = shadow_list[$urandom_range(0, shadow_len - 1)];
		end else if ($urandom_range(0, 3) == 0) begin
			// narrow alphabet breeds duplicates so find must report the first one
			r.value = FIRST_CHAR + VAL_W'($urandom_range(0, 3));
		end
		return r;
	endfunction

	function automatic void add_row(input opcode_t op, input int pos, input logic [7:0] val,
			input bit typed, input status_t st, input logic [7:0] dat, input int fnd,
			input int len);
		script_row_t row;
		row.item.opcode = op;
		row.item.position = POS_W'(pos);
		row.item.value = val;
		row.typed = typed;
		row.want.status = st;
		row.want.data = dat;
		row.want.found_position = POS_W'(fnd);
		row.want.list_length = POS_W'(len);
		opening_script.push_back(row);
	endfunction

	// drive one item from a falling edge, hold until taken, book its result
	task automatic put_item(input req_t item, input bit typed, input rsp_t typed_rsp);
		rsp_t predicted;
		req_if.valid <= 1'b1;
		req_if.payload <= item;
		do @(posedge clk); while (!req_if.ready);
		predicted = apply_list_op(item);
		list_replies_due.push_back(typed ? typed_rsp : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// sender works in bursts; between bursts valid may drop for a random gap
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 24);
		case ($urandom_range(0, 5))
			0, 1: gap = 0;
			2, 3, 4: gap = $urandom_range(1, 4);
			default: gap = $urandom_range(5, 20);
		endcase
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver: stretches of always-ready, random ready seven times in ten, and stall runs
	always @(negedge clk) begin
		logic next_ready;
		next_ready = 1'b0;
		if (arst_n) begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_mode_left = $urandom_range(32, 256);
				stall_run = 0;
			end else begin
				stall_mode_left--;
			end
			case (stall_mode)
				0: next_ready = 1'b1;
				1: next_ready = ($urandom_range(0, 9) < 7);
				default: begin
					// alternate runs of low and high ready; low runs may last longer than high ones
					if (stall_run == 0) begin
						stall_run = rsp_if.ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
						next_ready = !rsp_if.ready;
					end else begin
						next_ready = rsp_if.ready;
					end
					stall_run--;
				end
			endcase
		end
		rsp_if.ready <= next_ready;
	end

	// result checker: every taken result against the oldest booked one
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (list_replies_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: status %0d len %0d",
					got.status, got.list_length));
			end else begin
				want = list_replies_due.pop_front();
				results_checked++;
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got.status, want.status));
				if (got.data !== want.data)
					report_mismatch($sformatf("data got %0h want %0h", got.data, want.data));
				if (got.found_position !== want.found_position)
					report_mismatch($sformatf("found_position got %0d want %0d",
						got.found_position, want.found_position));
				if (got.list_length !== want.list_length)
					report_mismatch($sformatf("list_length got %0d want %0d",
						got.list_length, want.list_length));
				status_seen[int'(want.status)]++;
				if (32'(want.list_length) > peak_len) peak_len = 32'(want.list_length);
				if (want.list_length == 0) empty_hits++;
			end
		end
	end

	// hard stop if the core hangs
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		script_row_t row;
		req_t        item;
		rsp_t        none;
		bit          growing;
		int unsigned n;

		req_if.valid = 1'b0;
		req_if.payload = '0;
		none = '0;
		growing = 1'b1;
		burst_left = 0;

		// shadow list starts as the letters a..e
		shadow_len = 0;
		for (int c = FIRST_CHAR; c <= LAST_CHAR; c++) begin
			shadow_list[shadow_len] = VAL_W'(c);
			shadow_len++;
		end

		// opening script: typed rows come straight from the reset contents and error rules
		add_row(OP_READ,     1, 8'h00,            1, ST_OK,       FIRST_CHAR, 0, 5);
		add_row(OP_READ,     5, 8'hff,            1, ST_OK,       LAST_CHAR,  0, 5);
		add_row(OP_READ,     0, 8'h00,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_READ,     6, 8'h00,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_DELETE,   0, 8'hff,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_DELETE, 127, 8'h00,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_INSERT,   6, 8'h5a,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_INSERT, 127, 8'hff,            1, ST_RANGE,    8'h00,      0, 5);
		add_row(OP_FIND,     0, FIRST_CHAR + 8'd2, 1, ST_OK,      8'h00,      3, 5);
		add_row(OP_FIND,     0, 8'h00,            1, ST_NOTFOUND, 8'h00,      0, 5);
		add_row(OP_FIND,   127, 8'hff,            1, ST_NOTFOUND, 8'h00,      0, 5);
		add_row(OP_INSERT,   0, 8'h00,            1, ST_OK,       8'h00,      0, 6);
		add_row(OP_INSERT,   6, 8'hff,            1, ST_OK,       8'h00,      0, 7);
		// from here on the shadow list decides
		add_row(OP_READ,     1, 8'hff,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_READ,     7, 8'h00,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_INSERT,   2, FIRST_CHAR + 8'd2, 0, ST_OK,      8'h00,      0, 0);
		add_row(OP_FIND,    64, FIRST_CHAR + 8'd2, 0, ST_OK,      8'h00,      0, 0);
		add_row(OP_FIND,     0, 8'h00,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_DELETE,   1, 8'h00,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_DELETE,   7, 8'h00,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_DELETE,   3, 8'hff,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_READ,   127, 8'h00,            0, ST_OK,       8'h00,      0, 0);
		add_row(OP_FIND,     0, FIRST_CHAR + 8'd2, 0, ST_OK,      8'h00,      0, 0);

		// single reset at the start
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_script[k]) begin
			row = opening_script[k];
			put_item(row.item, row.typed, row.want);
			pace_sender();
		end

		// random part: swing between filling to full and draining to empty
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			item = pick_request(growing);
			put_item(item, 1'b0, none);
			// linger a little at full and empty so those corners see traffic
			if (growing && shadow_len == LIST_CAP && $urandom_range(0, 7) == 0)
				growing = 1'b0;
			else if (!growing && shadow_len == 0 && $urandom_range(0, 7) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 299) == 0)
				growing = !growing;
			pace_sender();
		end
		req_if.valid <= 1'b0;

		// drain, then keep the clock running so anything stray from the two-stage pipe shows up
		while (list_replies_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d items, %0d results checked, peak length %0d, empty %0d times",
			items_sent, results_checked, peak_len, empty_hits);
		$display("outcomes: ok %0d, out of range %0d, not found %0d, list full %0d",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_NOTFOUND],
			status_seen[ST_FULL]);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
